/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is applied
`define RLD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on the first edge after an edge that saw reset applied
`define RLD_ASSERT_RESET(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

/* rtl/core/rld_pkg.sv */
`timescale 1ns / 1ps

package rld_pkg;

  // store geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned TOT_W      = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned AMOUNT_W   = 32;
  localparam int unsigned SYMBOL_W   = 8;
  localparam int unsigned OUT_CNT_W  = 38;
  localparam int unsigned STATUS_W   = 2;

  // packed stream words, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = ((AMOUNT_W + SYMBOL_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OUT_CNT_W + SYMBOL_W + STATUS_W + 7) / 8) * 8;

  // accumulator sum width, one carry bit above the wider operand
  localparam int unsigned SUM_W = ((OUT_CNT_W > COUNT_BITS) ? OUT_CNT_W : COUNT_BITS) + 1;

  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ         = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                push;
    logic                start;
    logic                advance;
    logic                acc_add;
    logic                acc_load;
    logic                trim;
    logic                emit;
    logic                emit_run;
    logic                emit_last;
    logic [STATUS_W-1:0] emit_status;
  } rld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              amount_zero;
    logic              total_zero;
    logic              full;
    logic              hit;
    logic              at_end;
    logic              same_sym;
    logic              first;
    logic              out_free;
  } rld_stat_t;

  // push amount limited to the stored count width
  function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [AMOUNT_W-1:0] a);
    logic [AMOUNT_W+COUNT_BITS-1:0] wide;
    wide = {{COUNT_BITS{1'b0}}, a};
    if (wide > {{AMOUNT_W{1'b0}}, {COUNT_BITS{1'b1}}}) begin
      return '1;
    end
    return wide[COUNT_BITS-1:0];
  endfunction

  // circular slot of position pos counted from head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* rtl/core/rld_datapath.sv */
`timescale 1ns / 1ps

module rld_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rld_pkg::IN_DATA_W-1:0]     in_tdata_i,
  input  logic [rld_pkg::KIND_W-1:0]        in_tuser_i,
  input  rld_pkg::rld_cmd_t                 cmd_i,
  output rld_pkg::rld_stat_t                stat_o,
  input  logic                              out_tready_i,
  output logic                              out_tvalid_o,
  output logic [rld_pkg::OUT_DATA_W-1:0]    out_tdata_o,
  output logic                              out_tlast_o
);

  // captured transaction
  logic [rld_pkg::KIND_W-1:0]     kind_q;
  logic [rld_pkg::AMOUNT_W-1:0]   amount_q;
  logic [rld_pkg::SYMBOL_W-1:0]   symbol_q;

  // deque bookkeeping and walk position
  logic [rld_pkg::IDX_W-1:0]      head_q, head_d;
  logic [rld_pkg::TOT_W-1:0]      total_q, total_d;
  logic [rld_pkg::TOT_W-1:0]      k_q, k_d;

  // run accumulator
  logic [rld_pkg::OUT_CNT_W-1:0]  acc_q;
  logic [rld_pkg::SYMBOL_W-1:0]   sym_q;

  // output register
  logic                           out_valid_q;
  logic [rld_pkg::OUT_CNT_W-1:0]  out_cnt_q;
  logic [rld_pkg::SYMBOL_W-1:0]   out_sym_q;
  logic                           out_last_q;
  logic [rld_pkg::STATUS_W-1:0]   out_status_q;

  // run store
  logic [rld_pkg::SYMBOL_W-1:0]   mem_sym_q [rld_pkg::DEPTH];
  logic [rld_pkg::COUNT_BITS-1:0] mem_cnt_q [rld_pkg::DEPTH];
  logic [rld_pkg::SYMBOL_W-1:0]   rd_sym_q;
  logic [rld_pkg::COUNT_BITS-1:0] rd_cnt_q;

  logic                           wr_en;
  logic [rld_pkg::IDX_W-1:0]      wr_addr;
  logic [rld_pkg::SYMBOL_W-1:0]   wr_sym;
  logic [rld_pkg::COUNT_BITS-1:0] wr_cnt;
  logic [rld_pkg::IDX_W-1:0]      rd_addr;

  logic                           walk_back;
  logic [rld_pkg::TOT_W-1:0]      back_rd_pos, back_cur_pos;
  logic [rld_pkg::IDX_W-1:0]      rd_pos, cur_pos, cur_slot, push_slot;
  logic [rld_pkg::SUM_W-1:0]      sum_w, rem_w, amount_w, rd_cnt_w;
  logic [rld_pkg::OUT_CNT_W-1:0]  sum_sat, load_sat;
  logic                           exact;
  logic [rld_pkg::TOT_W-1:0]      dropped;

  // walk addressing: front to back, or back to front for a back removal
  assign walk_back    = (kind_q == rld_pkg::KIND_REMOVE_BACK);
  assign back_rd_pos  = total_q - rld_pkg::TOT_W'(1) - k_d;
  assign back_cur_pos = total_q - rld_pkg::TOT_W'(1) - k_q;
  assign rd_pos  = walk_back ? back_rd_pos[rld_pkg::IDX_W-1:0] : k_d[rld_pkg::IDX_W-1:0];
  assign cur_pos = walk_back ? back_cur_pos[rld_pkg::IDX_W-1:0] : k_q[rld_pkg::IDX_W-1:0];
  assign rd_addr  = rld_pkg::slot_of(head_q, rd_pos);
  assign cur_slot = rld_pkg::slot_of(head_q, cur_pos);

  // push target: behind the last run, or ahead of the head
  assign push_slot = (kind_q == rld_pkg::KIND_PUSH_BACK)
                   ? rld_pkg::slot_of(head_q, total_q[rld_pkg::IDX_W-1:0])
                   : rld_pkg::slot_of(head_q, rld_pkg::IDX_W'(rld_pkg::DEPTH - 1));

  // accumulate and compare against the removal amount
  assign amount_w = rld_pkg::SUM_W'(amount_q);
  assign rd_cnt_w = rld_pkg::SUM_W'(rd_cnt_q);
  assign sum_w    = rld_pkg::SUM_W'(acc_q) + rd_cnt_w;
  assign rem_w    = sum_w - amount_w;
  assign exact    = (sum_w == amount_w);
  assign dropped  = exact ? (k_q + rld_pkg::TOT_W'(1)) : k_q;
  assign sum_sat  = (sum_w > rld_pkg::SUM_W'(rld_pkg::OUT_CNT_MAX))
                  ? rld_pkg::OUT_CNT_MAX : sum_w[rld_pkg::OUT_CNT_W-1:0];
  assign load_sat = (rd_cnt_w > rld_pkg::SUM_W'(rld_pkg::OUT_CNT_MAX))
                  ? rld_pkg::OUT_CNT_MAX : rd_cnt_w[rld_pkg::OUT_CNT_W-1:0];

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = push_slot;
    wr_sym  = symbol_q;
    wr_cnt  = rld_pkg::clamp_count(amount_q);
    if (cmd_i.push) begin
      wr_en = 1'b1;
    end else if (cmd_i.trim && !exact) begin
      wr_en   = 1'b1;
      wr_addr = cur_slot;
      wr_sym  = rd_sym_q;
      wr_cnt  = rem_w[rld_pkg::COUNT_BITS-1:0];
    end
  end

  // next head, fill and walk position
  always_comb begin
    head_d  = head_q;
    total_d = total_q;
    k_d     = k_q;
    if (cmd_i.push) begin
      total_d = total_q + rld_pkg::TOT_W'(1);
      if (kind_q == rld_pkg::KIND_PUSH_FRONT) begin
        head_d = push_slot;
      end
    end
    if (cmd_i.trim) begin
      total_d = total_q - dropped;
      if (!walk_back) begin
        head_d = rld_pkg::slot_of(head_q, dropped[rld_pkg::IDX_W-1:0]);
      end
    end
    if (cmd_i.start) begin
      k_d = '0;
    end else if (cmd_i.advance) begin
      k_d = k_q + rld_pkg::TOT_W'(1);
    end
  end

  // run store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_sym_q[wr_addr] <= wr_sym;
      mem_cnt_q[wr_addr] <= wr_cnt;
    end
    rd_sym_q <= mem_sym_q[rd_addr];
    rd_cnt_q <= mem_cnt_q[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      total_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      total_q <= total_d;
      k_q     <= k_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= in_tuser_i;
      amount_q <= in_tdata_i[rld_pkg::AMOUNT_W-1:0];
      symbol_q <= in_tdata_i[rld_pkg::AMOUNT_W +: rld_pkg::SYMBOL_W];
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (cmd_i.acc_load) begin
      acc_q <= load_sat;
      sym_q <= rd_sym_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= sum_sat;
    end
    if (cmd_i.emit) begin
      out_cnt_q    <= cmd_i.emit_run ? acc_q : '0;
      out_sym_q    <= cmd_i.emit_run ? sym_q : '0;
      out_last_q   <= cmd_i.emit_last;
      out_status_q <= cmd_i.emit_status;
    end
  end

  // status back to the controller
  always_comb begin
    stat_o.kind        = kind_q;
    stat_o.amount_zero = (amount_q == '0);
    stat_o.total_zero  = (total_q == '0);
    stat_o.full        = (total_q >= rld_pkg::TOT_W'(rld_pkg::DEPTH));
    stat_o.hit         = (sum_w >= amount_w);
    stat_o.at_end      = ((k_q + rld_pkg::TOT_W'(1)) == total_q);
    stat_o.same_sym    = (rd_sym_q == sym_q);
    stat_o.first       = (k_q == '0);
    stat_o.out_free    = !out_valid_q || out_tready_i;
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tlast_o  = out_last_q;
  assign out_tdata_o  = rld_pkg::OUT_DATA_W'({out_status_q, out_sym_q, out_cnt_q});

endmodule

/* rtl/core/rld_ctrl.sv */
`timescale 1ns / 1ps

module rld_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_tvalid_i,
  output logic               in_tready_o,
  input  rld_pkg::rld_stat_t stat_i,
  output rld_pkg::rld_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK_REMOVE,
    S_WALK_READ,
    S_FINAL,
    S_RESULT
  } state_e;

  state_e                       state_q, state_d;
  logic [rld_pkg::STATUS_W-1:0] res_status_q, res_status_d;

  assign in_tready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d      = S_RESULT;
        res_status_d = rld_pkg::ST_OK;
        unique case (stat_i.kind) inside
          rld_pkg::KIND_PUSH_BACK, rld_pkg::KIND_PUSH_FRONT: begin
            if (stat_i.full) begin
              res_status_d = rld_pkg::ST_FULL;
            end else if (!stat_i.amount_zero) begin
              cmd_o.push = 1'b1;
            end
          end
          rld_pkg::KIND_REMOVE_BACK, rld_pkg::KIND_REMOVE_FRONT: begin
            if (stat_i.amount_zero) begin
              res_status_d = rld_pkg::ST_OK;
            end else if (stat_i.total_zero) begin
              res_status_d = rld_pkg::ST_SHORT;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_WALK_REMOVE;
            end
          end
          rld_pkg::KIND_READ: begin
            if (stat_i.total_zero) begin
              res_status_d = rld_pkg::ST_EMPTY;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_WALK_READ;
            end
          end
          default: begin
            res_status_d = rld_pkg::ST_OK;
          end
        endcase
      end
      S_WALK_REMOVE: begin
        // boundary run found, or whole deque walked without reaching the amount
        if (stat_i.hit) begin
          cmd_o.trim   = 1'b1;
          res_status_d = rld_pkg::ST_OK;
          state_d      = S_RESULT;
        end else if (stat_i.at_end) begin
          res_status_d = rld_pkg::ST_SHORT;
          state_d      = S_RESULT;
        end else begin
          cmd_o.acc_add = 1'b1;
          cmd_o.advance = 1'b1;
        end
      end
      S_WALK_READ: begin
        if (stat_i.first || stat_i.same_sym || stat_i.out_free) begin
          if (stat_i.first) begin
            cmd_o.acc_load = 1'b1;
          end else if (stat_i.same_sym) begin
            cmd_o.acc_add = 1'b1;
          end else begin
            // symbol changes: hand out the merged run and start a new one
            cmd_o.emit        = 1'b1;
            cmd_o.emit_run    = 1'b1;
            cmd_o.emit_status = rld_pkg::ST_OK;
            cmd_o.acc_load    = 1'b1;
          end
          if (stat_i.at_end) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_run    = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = rld_pkg::ST_OK;
          state_d           = S_IDLE;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = res_status_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= rld_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
    end
  end

endmodule

/* rtl/core/run_length_deque.sv */
`timescale 1ns / 1ps
// channel  direction  tdata (low bit up)                    tuser  tlast
// s_axis   in         amount[31:0], symbol[39:32]           kind   -
// m_axis   out        run_count[37:0], run_symbol[45:38],   -      last
//                     status[47:46]
//
// a push goes from transaction to result through capture, decide and result
// a removal walks the stored runs from the removal end between decide and
// result; one store read port walks one run a cycle
// a read-out walks every stored run in turn, then hands out the last merged run
// every result waits while the output register is held by m_axis_tready low
// reset clears head, fill, walk position and output valid; no clearing pass over the run store

module run_length_deque (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rld_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // amount, symbol
  input  logic [rld_pkg::KIND_W-1:0]     s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rld_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // run_count, run_symbol, status
  output logic                           m_axis_tlast   // last
);

  rld_pkg::rld_cmd_t  cmd;
  rld_pkg::rld_stat_t stat;

  // sequencer
  rld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // run store, accumulator and output register
  rld_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tlast_o  (m_axis_tlast)
  );

endmodule

/* rtl/core/rld_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rld_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  logic [rld_pkg::STATUS_W-1:0] out_status;
  logic                         out_fields_zero;

  assign out_status = m_axis_tdata[rld_pkg::OUT_CNT_W + rld_pkg::SYMBOL_W +: rld_pkg::STATUS_W];
  assign out_fields_zero = (m_axis_tdata[rld_pkg::OUT_CNT_W + rld_pkg::SYMBOL_W - 1:0] == '0);

  // no result straight out of reset
  `RLD_ASSERT_RESET(a_no_result_after_reset, clk_i, rst_ni, !m_axis_tvalid, "result valid after reset")

  // a stalled result holds
  `RLD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // one transaction at a time
  `RLD_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready held after transaction")

  // only the last result of a read-out may be preceded by others, all ok
  `RLD_ASSERT(a_mid_run_ok, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast |-> out_status == rld_pkg::ST_OK, "non-final result with error status")

  // error results carry no run
  `RLD_ASSERT(a_error_no_run, clk_i, rst_ni, m_axis_tvalid && out_status != rld_pkg::ST_OK |-> out_fields_zero && m_axis_tlast, "error result carries run data")

endmodule

bind run_length_deque rld_checker u_rld_checker (.*);
